/* rtl/core/mf3_pkg.sv */
// Shared constants and types of the 3x3 median stream filter.
// No dependencies; compiled first.
package mf3_pkg;

    localparam int MAX_WIDTH_DEFAULT = 32;

    localparam int PIXEL_W = 8;
    typedef logic [PIXEL_W-1:0] pixel_t;

    localparam int WIDTH_REG_W  = 6;
    localparam int HEIGHT_REG_W = 7;
    typedef logic [WIDTH_REG_W-1:0]  width_cfg_t;
    typedef logic [HEIGHT_REG_W-1:0] height_cfg_t;

    localparam width_cfg_t  WIDTH_RESET  = 6'd32;
    localparam height_cfg_t HEIGHT_RESET = 7'd32;
    localparam int MIN_DIM = 3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    localparam int WIN_SIZE         = 9;
    localparam int MEDIAN_POS       = 4;
    localparam int NET_STAGES       = 12;
    localparam int LAYERS_PER_STAGE = 4;
    localparam int NET_PIPE         = NET_STAGES / LAYERS_PER_STAGE;

    localparam int OUT_DEPTH = 4;

endpackage

/* rtl/core/mf3_pix_in_if.sv */
// Input pixel channel: valid/ready handshake carrying one raster pixel.
// Depends on mf3_pkg.
interface mf3_pix_in_if;
    import mf3_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

/* rtl/core/mf3_pix_out_if.sv */
// Output pixel channel: valid/ready handshake carrying a filtered pixel and its run mark.
// Depends on mf3_pkg.
interface mf3_pix_out_if;
    import mf3_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel_out;
    logic   last_in_run;

    modport source (output valid, output pixel_out, output last_in_run, input ready);
    modport sink   (input valid, input pixel_out, input last_in_run, output ready);
endinterface

/* rtl/core/mf3_cfg_if.sv */
// Configuration write channel: valid/ready handshake carrying register index and data.
// Depends on mf3_pkg.
interface mf3_cfg_if;
    import mf3_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/median_3x3_stream_filter.sv */
// 3x3 median filter over a raster pixel stream: line memory, window, sort pipeline, output queue.
// Depends on mf3_pkg, mf3_pix_in_if, mf3_pix_out_if, mf3_cfg_if.

// The filter takes one 8-bit pixel per clock while its input is not held or stalled, and
// sustains one output word per clock while the output is ready. A pixel is read against the
// line memory (one entry per column, holding the two rows above) in the cycle it is accepted,
// written back when it leaves stage 1, and its window median then passes the three-stage sort
// pipeline into the output queue. Row 0 passes through, row 1 is held back, inner pixels of
// later rows are medians, and border columns are raw. The frame's final pixel releases the
// last row: that pixel gives frame_width + 2 words, and input is held until the single
// memory read port has streamed the stored row into the output queue. No clearing pass runs
// after reset. Writing frame_width or frame_height restarts the frame; write them only
// while the block is idle.
module median_3x3_stream_filter #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    mf3_pix_in_if.sink    pix_in,
    mf3_pix_out_if.source pix_out,
    mf3_cfg_if.sink       cfg
);
    import mf3_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
    localparam int NSTG    = NET_PIPE + 1;
    localparam int PTR_W   = $clog2(OUT_DEPTH);
    localparam int CNT_W   = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic emit;
        logic raw_is_pixel;
        logic use_median;
        logic has_second;
        logic burst;
    } kind_t;

    typedef struct packed {
        pixel_t [WIN_SIZE-1:0] vals;
        pixel_t                raw;
        logic                  use_median;
        logic                  has_second;
        logic                  burst;
    } item_t;

    typedef struct packed {
        pixel_t pixel;
        logic   last;
    } word_t;

    typedef struct packed {
        pixel_t cur;
        pixel_t up1;
        pixel_t up2;
    } column_t;

    function automatic item_t net_layers(input item_t it, input int first);
        item_t  r;
        pixel_t t;
        int     l;
        int     p;
        r = it;
        for (l = 0; l < LAYERS_PER_STAGE; l++)
        begin
            for (p = 0; p + 1 < WIN_SIZE; p++)
            begin
                if ((((p + first + l) & 1) == 0) && (r.vals[p] > r.vals[p+1]))
                begin
                    t           = r.vals[p];
                    r.vals[p]   = r.vals[p+1];
                    r.vals[p+1] = t;
                end
            end
        end
        return r;
    endfunction

    width_cfg_t         width_cfg_reg;
    height_cfg_t        height_cfg_reg;
    logic [WIDTH_W-1:0] eff_w;
    height_cfg_t        eff_h;

    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    height_cfg_t        row_reg;
    height_cfg_t        row_next;
    logic               last_col;
    logic               last_row;
    kind_t              kind_in;
    logic               in_ready;
    logic               accept;
    logic               cfg_write;

    logic               s1_valid_reg;
    pixel_t             s1_pixel_reg;
    logic [COL_W-1:0]   s1_col_reg;
    kind_t              s1_kind_reg;
    logic               s1_adv;
    column_t            cur_col;
    item_t              s1_item;
    column_t            win_reg [2];

    logic [2*PIXEL_W-1:0] mem [MAX_WIDTH];
    logic [2*PIXEL_W-1:0] mem_rd_reg;
    logic                 rd_en;
    logic [COL_W-1:0]     rd_addr;

    item_t              stg_reg [NSTG];
    item_t              stg_in  [NSTG];
    logic [NSTG-1:0]    stg_valid_reg;
    logic [NSTG-1:0]    stg_adv;
    logic [NSTG-1:0]    stg_load;
    item_t              tail;
    logic               out_room;

    word_t              fifo_reg [OUT_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    word_t              push0;
    word_t              push1;
    logic [1:0]         n_push;
    logic               pop;

    logic               hold_reg;
    logic               burst_active_reg;
    logic [COL_W-1:0]   burst_addr_reg;
    logic               burst_rd_valid_reg;
    logic               burst_rd_last_reg;
    logic               burst_issue;
    logic               burst_issue_last;

    // effective frame size
    always_comb
    begin
        if (width_cfg_reg < WIDTH_REG_W'(MIN_DIM))
            eff_w = WIDTH_W'(MIN_DIM);
        else if (width_cfg_reg > WIDTH_REG_W'(MAX_WIDTH))
            eff_w = WIDTH_W'(MAX_WIDTH);
        else
            eff_w = WIDTH_W'(width_cfg_reg);
        eff_h = (height_cfg_reg < HEIGHT_REG_W'(MIN_DIM)) ? HEIGHT_REG_W'(MIN_DIM)
                                                           : height_cfg_reg;
    end

    // position and output kind of the incoming pixel
    always_comb
    begin
        last_col = (WIDTH_W'(col_reg) == (eff_w - WIDTH_W'(1)));
        last_row = (row_reg == (eff_h - HEIGHT_REG_W'(1)));
        col_next = last_col ? '0 : col_reg + COL_W'(1);
        if (last_col)
            row_next = last_row ? '0 : row_reg + HEIGHT_REG_W'(1);
        else
            row_next = row_reg;

        kind_in = '0;
        if (row_reg == '0)
        begin
            kind_in.emit         = 1'b1;
            kind_in.raw_is_pixel = 1'b1;
        end
        else if (row_reg != HEIGHT_REG_W'(1))
        begin
            if (col_reg == '0)
            begin
                kind_in.emit = 1'b1;
            end
            else if (col_reg != COL_W'(1))
            begin
                kind_in.emit       = 1'b1;
                kind_in.use_median = 1'b1;
                kind_in.has_second = last_col;
                kind_in.burst      = last_col && last_row;
            end
        end
    end

    assign s1_adv   = s1_valid_reg &&
                      (!s1_kind_reg.emit || !stg_valid_reg[0] || stg_adv[0]);
    assign in_ready = !hold_reg && (!s1_valid_reg || s1_adv);
    assign accept   = pix_in.valid && in_ready;
    assign pix_in.ready = in_ready;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    // config registers and frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH:
                begin
                    width_cfg_reg <= cfg.data[WIDTH_REG_W-1:0];
                    col_reg       <= '0;
                    row_reg       <= '0;
                end
                REG_FRAME_HEIGHT:
                begin
                    height_cfg_reg <= cfg.data[HEIGHT_REG_W-1:0];
                    col_reg        <= '0;
                    row_reg        <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: pixel waits for its column from the line memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept || (s1_valid_reg && !s1_adv);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pix_in.pixel_in;
            s1_col_reg   <= col_reg;
            s1_kind_reg  <= kind_in;
        end
    end

    always_comb
    begin
        cur_col.cur = s1_pixel_reg;
        cur_col.up1 = mem_rd_reg[PIXEL_W-1:0];
        cur_col.up2 = mem_rd_reg[2*PIXEL_W-1:PIXEL_W];

        s1_item.vals[0]    = cur_col.cur;
        s1_item.vals[1]    = win_reg[0].cur;
        s1_item.vals[2]    = win_reg[1].cur;
        s1_item.vals[3]    = cur_col.up1;
        s1_item.vals[4]    = win_reg[0].up1;
        s1_item.vals[5]    = win_reg[1].up1;
        s1_item.vals[6]    = cur_col.up2;
        s1_item.vals[7]    = win_reg[0].up2;
        s1_item.vals[8]    = win_reg[1].up2;
        s1_item.raw        = s1_kind_reg.raw_is_pixel ? cur_col.cur : cur_col.up1;
        s1_item.use_median = s1_kind_reg.use_median;
        s1_item.has_second = s1_kind_reg.has_second;
        s1_item.burst      = s1_kind_reg.burst;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            win_reg[1] <= win_reg[0];
            win_reg[0] <= cur_col;
        end
    end

    // line memory: entry per column, {row-2, row-1}
    assign rd_en   = accept || burst_issue;
    assign rd_addr = burst_issue ? burst_addr_reg : col_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            mem[s1_col_reg] <= {cur_col.up1, cur_col.cur};
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            mem_rd_reg <= mem[rd_addr];
    end

    // sort pipeline
    always_comb
    begin
        int k;
        stg_in[0] = s1_item;
        for (k = 1; k < NSTG; k++)
            stg_in[k] = net_layers(stg_reg[k-1], (k - 1) * LAYERS_PER_STAGE);
    end

    assign tail     = stg_reg[NSTG-1];
    assign out_room = (cnt_reg <= CNT_W'(OUT_DEPTH - 2));

    always_comb
    begin
        int k;
        stg_adv[NSTG-1] = stg_valid_reg[NSTG-1] && out_room;
        for (k = NSTG - 2; k >= 0; k--)
            stg_adv[k] = stg_valid_reg[k] && (!stg_valid_reg[k+1] || stg_adv[k+1]);
        stg_load[0] = s1_adv && s1_kind_reg.emit;
        for (k = 1; k < NSTG; k++)
            stg_load[k] = stg_adv[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= '0;
        else
            stg_valid_reg <= stg_load | (stg_valid_reg & ~stg_adv);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (stg_load[k])
                stg_reg[k] <= stg_in[k];
        end
    end

    // output queue
    always_comb
    begin
        push0  = '0;
        push1  = '0;
        n_push = 2'd0;
        if (stg_adv[NSTG-1])
        begin
            push0.pixel = tail.use_median ? tail.vals[MEDIAN_POS] : tail.raw;
            push0.last  = !tail.has_second && !tail.burst;
            push1.pixel = tail.raw;
            push1.last  = !tail.burst;
            n_push      = tail.has_second ? 2'd2 : 2'd1;
        end
        else if (burst_rd_valid_reg)
        begin
            push0.pixel = mem_rd_reg[PIXEL_W-1:0];
            push0.last  = burst_rd_last_reg;
            n_push      = 2'd1;
        end
    end

    assign pix_out.valid       = (cnt_reg != '0);
    assign pix_out.pixel_out   = fifo_reg[rd_ptr_reg].pixel;
    assign pix_out.last_in_run = fifo_reg[rd_ptr_reg].last;
    assign pop = pix_out.valid && pix_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_push);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            cnt_reg    <= cnt_reg + CNT_W'(n_push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            fifo_reg[wr_ptr_reg] <= push0;
        if (n_push == 2'd2)
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= push1;
    end

    // last-row burst: stream the stored row out of the line memory
    assign burst_issue = burst_active_reg &&
                         ((cnt_reg + CNT_W'(burst_rd_valid_reg)) < CNT_W'(OUT_DEPTH));
    assign burst_issue_last = burst_issue &&
                              (WIDTH_W'(burst_addr_reg) == (eff_w - WIDTH_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg           <= 1'b0;
            burst_active_reg   <= 1'b0;
            burst_addr_reg     <= '0;
            burst_rd_valid_reg <= 1'b0;
            burst_rd_last_reg  <= 1'b0;
        end
        else
        begin
            burst_rd_valid_reg <= burst_issue;
            burst_rd_last_reg  <= burst_issue_last;

            if (accept && kind_in.burst)
                hold_reg <= 1'b1;
            else if (burst_issue_last)
                hold_reg <= 1'b0;

            if (stg_adv[NSTG-1] && tail.burst)
            begin
                burst_active_reg <= 1'b1;
                burst_addr_reg   <= '0;
            end
            else if (burst_issue)
            begin
                if (burst_issue_last)
                    burst_active_reg <= 1'b0;
                else
                    burst_addr_reg <= burst_addr_reg + COL_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    ap_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(OUT_DEPTH))
        else $error("output queue overflow");

    ap_burst_alone: assert property (@(posedge clk) disable iff (!rst_n)
        burst_active_reg |-> (!s1_valid_reg && (stg_valid_reg == '0)))
        else $error("row burst overlaps pipeline traffic");

    ap_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && rd_en) |-> (rd_addr != s1_col_reg))
        else $error("line memory read and write hit the same column");

    ap_hold_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind_in.burst) |=> (hold_reg && !pix_in.ready))
        else $error("input not held after final frame pixel");
`endif

endmodule

/* tb/sv/tb_median_3x3_stream_filter.sv */
// Self-checking testbench for median_3x3_stream_filter: directed and random frames are checked
// word by word against a pixel-level predictor, under random idling and one long output hold-off.
// Depends on mf3_pkg, mf3_pix_in_if, mf3_pix_out_if, mf3_cfg_if and the filter RTL.
module tb_median_3x3_stream_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    localparam int STORE_DEPTH     = 2 * MAX_WIDTH_DEFAULT + 3;
    localparam int SETTLE_CYCLES   = 16;
    localparam int DRAIN_CYCLES    = 32;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int STALL_LIMIT     = 1000;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        pixel_t pix;
        logic   last;
    } out_word_t;

    logic clk;
    logic rst_n;

    mf3_pix_in_if  pix_in_bus ();
    mf3_pix_out_if pix_out_bus ();
    mf3_cfg_if     cfg_bus ();

    median_3x3_stream_filter u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_bus),
        .pix_out (pix_out_bus),
        .cfg     (cfg_bus)
    );

    pixel_t      line_mem [STORE_DEPTH];
    width_cfg_t  width_reg  = WIDTH_RESET;
    height_cfg_t height_reg = HEIGHT_RESET;
    int unsigned col_pos    = 0;
    int unsigned row_pos    = 0;
    out_word_t   filtered_words [$];

    int error_count  = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_off_req = 1'b0;

    function automatic int unsigned eff_width();
        if (width_reg < MIN_DIM)
            return MIN_DIM;
        if (width_reg > MAX_WIDTH_DEFAULT)
            return MAX_WIDTH_DEFAULT;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg < MIN_DIM)
            return MIN_DIM;
        return height_reg;
    endfunction

    function automatic pixel_t window_median(int unsigned w);
        pixel_t win [WIN_SIZE];
        pixel_t held;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r * 3 + c] = line_mem[r * w + c];
        for (int s = 0; s < NET_STAGES; s++)
            for (int p = s % 2; p + 1 < WIN_SIZE; p += 2)
                if (win[p] > win[p + 1])
                begin
                    held       = win[p];
                    win[p]     = win[p + 1];
                    win[p + 1] = held;
                end
        return win[MEDIAN_POS];
    endfunction

    function automatic void predict_filter_words(pixel_t pix);
        int unsigned w;
        int unsigned h;
        pixel_t      words [$];
        w = eff_width();
        h = eff_height();
        for (int i = STORE_DEPTH - 1; i > 0; i--)
            line_mem[i] = line_mem[i - 1];
        line_mem[0] = pix;
        if (row_pos == 0)
            words.push_back(line_mem[0]);
        else if (row_pos >= 2)
        begin
            if (col_pos == 0)
                words.push_back(line_mem[w]);
            else if (col_pos >= 2)
            begin
                words.push_back(window_median(w));
                if (col_pos == w - 1)
                begin
                    words.push_back(line_mem[w]);
                    if (row_pos == h - 1)
                        for (int i = 0; i < w; i++)
                            words.push_back(line_mem[w - 1 - i]);
                end
            end
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
        foreach (words[k])
            filtered_words.push_back('{pix: words[k], last: (k == words.size() - 1)});
    endfunction

    function automatic void apply_reg_write(logic [CFG_INDEX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FRAME_WIDTH:  width_reg  = val[WIDTH_REG_W-1:0];
            REG_FRAME_HEIGHT: height_reg = val[HEIGHT_REG_W-1:0];
            default:          return;
        endcase
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic pixel_t random_pixel();
        case ($urandom_range(0, 4))
            0:       return pixel_t'($urandom_range(120, 135));
            1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return pixel_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t ns: %s", $realtime, msg);
    endtask

    task automatic send_pixel(input pixel_t pix);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pix_in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in_bus.valid    <= 1'b1;
        pix_in_bus.pixel_in <= pix;
        @(posedge clk);
        while (!pix_in_bus.ready)
            @(posedge clk);
        predict_filter_words(pix);
        @(negedge clk);
    endtask

    task automatic send_pixels(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(random_pixel());
    endtask

    task automatic wait_idle();
        pix_in_bus.valid <= 1'b0;
        while (filtered_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        apply_reg_write(idx, val);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic test_directed_frames();
        pixel_t corner_frame [9] = '{8'h00, 8'hFF, 8'h01,
                                     8'hFE, 8'h80, 8'h7F,
                                     8'h00, 8'hFF, 8'h80};
        pixel_t mixed_frame [16] = '{8'h55, 8'hAA, 8'h33, 8'hCC,
                                     8'h0F, 8'hF0, 8'h00, 8'hFF,
                                     8'h10, 8'h10, 8'h10, 8'hEF,
                                     8'h01, 8'h02, 8'h03, 8'hFD};
        send_pixel(8'h00);
        send_pixel(8'hFF);
        write_reg(REG_FRAME_WIDTH, 7'd0);
        write_reg(REG_FRAME_HEIGHT, 7'd2);
        foreach (corner_frame[i])
            send_pixel(corner_frame[i]);
        write_reg(REG_FRAME_WIDTH, 7'd4);
        write_reg(REG_FRAME_HEIGHT, 7'd4);
        foreach (mixed_frame[i])
            send_pixel(mixed_frame[i]);
    endtask

    task automatic test_tall_narrow_frame();
        write_reg(REG_FRAME_WIDTH, 7'd1);
        write_reg(REG_FRAME_HEIGHT, 7'd44);
        send_pixels(eff_width() * eff_height());
    endtask

    task automatic test_ignored_index();
        write_reg(REG_FRAME_WIDTH, 7'd5);
        write_reg(REG_FRAME_HEIGHT, 7'd4);
        send_pixels(7);
        write_reg(REG_SPARE_2, CFG_DATA_W'($urandom()));
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom()));
        send_pixels(13);
    endtask

    task automatic test_frame_restart();
        write_reg(REG_FRAME_WIDTH, 7'd32);
        write_reg(REG_FRAME_HEIGHT, 7'd32);
        send_pixels(68);
        write_reg(REG_FRAME_HEIGHT, 7'd3);
        send_pixels(40);
        write_reg(REG_FRAME_WIDTH, 7'd6);
        send_pixels(eff_width() * eff_height());
    endtask

    task automatic test_random_geometry(input int budget);
        int                    sent;
        int                    count;
        logic [CFG_DATA_W-1:0] wdata;
        sent = 0;
        while (sent < budget)
        begin
            wdata = CFG_DATA_W'($urandom_range(0, 10));
            if ($urandom_range(0, 1))
                wdata[CFG_DATA_W-1] = 1'b1;
            write_reg(REG_FRAME_WIDTH, wdata);
            write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(0, 6)));
            count = eff_width() * eff_height();
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, count - 1);
            send_pixels(count);
            sent += count;
        end
    endtask

    task automatic test_output_backpressure();
        write_reg(REG_FRAME_WIDTH, 7'h7F);
        write_reg(REG_FRAME_HEIGHT, 7'd0);
        hold_off_req = 1'b1;
        send_pixels(eff_width() * eff_height());
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : sink_ready
        int held;
        pix_out_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                begin
                    pix_out_bus.ready <= 1'b0;
                    @(negedge clk);
                end
            end
            pix_out_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_words
        out_word_t want;
        if (rst_n && pix_out_bus.valid && pix_out_bus.ready)
        begin
            if (filtered_words.size() == 0)
                flag_error($sformatf("unexpected word: pixel=%0d last=%0b",
                                     pix_out_bus.pixel_out, pix_out_bus.last_in_run));
            else
            begin
                want = filtered_words.pop_front();
                if (pix_out_bus.pixel_out !== want.pix || pix_out_bus.last_in_run !== want.last)
                    flag_error($sformatf(
                        "word mismatch: expected pixel=%0d last=%0b, got pixel=%0d last=%0b",
                        want.pix, want.last,
                        pix_out_bus.pixel_out, pix_out_bus.last_in_run));
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pix_in_bus.valid && pix_in_bus.ready) ||
                (pix_out_bus.valid && pix_out_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : run_tests
        pix_in_bus.valid    = 1'b0;
        pix_in_bus.pixel_in = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        foreach (line_mem[i])
            line_mem[i] = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct = 23;
        snk_idle_pct = 45;
        test_directed_frames();
        test_tall_narrow_frame();

        src_idle_pct = 45;
        snk_idle_pct = 23;
        test_ignored_index();
        test_frame_restart();
        test_random_geometry(30);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_output_backpressure();
        test_random_geometry(20);

        pix_in_bus.valid <= 1'b0;
        while (filtered_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && filtered_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
